[hw/rtl/hts_pkg.sv]
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, register codes and reset values for the hysteresis thermostat.
// ----------------------------------------------------------------------------
package hts_pkg;

	// Width of the relay and save timers.
	localparam int TIMER_W = 16;
	// Fraction bits of all temperatures and setpoints.
	localparam int TEMP_FRAC_BITS = 4;

	localparam int TEMP_W     = 12;
	localparam int DEB_W      = 8;
	localparam int REP_W      = 12;
	localparam int NUM_BUTTONS = 2;

	// Configuration register codes, in register map order.
	typedef enum logic [2:0] {
		REG_HALF_BAND     = 3'd0,
		REG_SETPOINT_LOW  = 3'd1,
		REG_SETPOINT_HIGH = 3'd2,
		REG_SETPOINT_STEP = 3'd3,
		REG_MIN_TOGGLE    = 3'd4,
		REG_DEBOUNCE      = 3'd5,
		REG_REPEAT        = 3'd6,
		REG_SAVE_QUIET    = 3'd7
	} cfg_reg_t;

	// Reset values; the temperature ones follow the fraction width.
	localparam logic [7:0]  HALF_BAND_RST  = 8'((3 * (1 << TEMP_FRAC_BITS)) / 4);
	localparam logic [11:0] SP_LOW_RST     = 12'(-5 * (1 << TEMP_FRAC_BITS));
	localparam logic [11:0] SP_HIGH_RST    = 12'(30 * (1 << TEMP_FRAC_BITS));
	localparam logic [7:0]  SP_STEP_RST    = 8'((1 << TEMP_FRAC_BITS) / 2);
	localparam logic [15:0] MIN_TOGGLE_RST = 16'd10000;
	localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;
	localparam logic [11:0] REPEAT_RST     = 12'd250;
	localparam logic [15:0] SAVE_QUIET_RST = 16'd3000;
	localparam logic [11:0] SETPOINT_RST   = 12'(8 * (1 << TEMP_FRAC_BITS));

	typedef struct packed {
		logic                     temp_valid;
		logic signed [TEMP_W-1:0] temperature;
		logic                     up_level;
		logic                     down_level;
		logic                     remote_write;
		logic signed [TEMP_W-1:0] remote_setpoint;
	} tick_item_t;

	typedef struct packed {
		logic                     relay_on;
		logic signed [TEMP_W-1:0] setpoint_now;
		logic                     save_pulse;
		logic                     local_change;
	} result_item_t;

endpackage

[hw/rtl/hysteresis_thermostat_with_buttons_top.sv]
// ----------------------------------------------------------------------------
// hysteresis_thermostat_with_buttons_top
// Hysteresis relay control with debounced, auto-repeating setpoint buttons.
// ----------------------------------------------------------------------------
// How to use this block:
// Each item on the src channel is one millisecond tick. It carries the probe
// sample, the two raw active-low button pins and an optional remote setpoint.
// For every tick item exactly one result item leaves on the res channel with
// the relay drive, the current setpoint, the save request and a flag that
// tells whether a button stepped the setpoint on that tick.
// An accepted item is held in an input register while all of its work is
// done, and the result then sits in an output register whose valid flag
// drives res_valid. A new item is taken every cycle while the receiver
// does not stall. The rate is set by the single update pass over the
// setpoint, button and timer state.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, and only then src_stall rises.
// The cfg channel is always ready and writes the indexed register; it is
// to be used while no tick is in flight. Reset restores all registers to
// their defaults, sets the setpoint to eight degrees, the relay off and both
// buttons released.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_with_buttons_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  hts_pkg::tick_item_t   src_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output hts_pkg::result_item_t res_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  hts_pkg::cfg_reg_t     cfg_index,
	input  logic [15:0]           cfg_data
);
	import hts_pkg::*;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
	localparam logic [DEB_W-1:0]   DEB_MAX   = '1;
	localparam logic [REP_W-1:0]   REP_MAX   = '1;

	// Configuration registers.
	logic [7:0]  half_band_q;
	logic [11:0] sp_low_q;
	logic [11:0] sp_high_q;
	logic [7:0]  sp_step_q;
	logic [15:0] min_toggle_q;
	logic [7:0]  debounce_q;
	logic [11:0] repeat_q;
	logic [15:0] save_quiet_q;

	// Block state.
	logic                     relay_q;
	logic [TIMER_W-1:0]       relay_age_q;
	logic signed [TEMP_W-1:0] setpoint_q;
	logic                     dirty_q;
	logic [TIMER_W-1:0]       quiet_age_q;
	logic                     stable_q [NUM_BUTTONS];
	logic                     last_q   [NUM_BUTTONS];
	logic [DEB_W-1:0]         db_age_q [NUM_BUTTONS];
	logic [REP_W-1:0]         rp_age_q [NUM_BUTTONS];

	// Input and result stages.
	logic         vld_s1;
	tick_item_t   item_s1;
	logic         res_vld_s2;
	result_item_t res_item_s2;

	logic advance;

	// Next-state values of the update pass.
	logic                     level    [NUM_BUTTONS];
	logic                     fire     [NUM_BUTTONS];
	logic                     stable_d [NUM_BUTTONS];
	logic [DEB_W-1:0]         db_age_d [NUM_BUTTONS];
	logic [REP_W-1:0]         rp_age_d [NUM_BUTTONS];
	logic                     remote_ok;
	logic                     mark;
	logic signed [TEMP_W-1:0] sp_remote;
	logic signed [TEMP_W-1:0] sp_up;
	logic signed [TEMP_W-1:0] sp_d;
	logic signed [13:0]       sp_lo_x;
	logic signed [13:0]       sp_hi_x;
	logic signed [13:0]       step_x;
	logic signed [13:0]       half_x;
	logic signed [13:0]       temp_x;
	logic [TIMER_W-1:0]       quiet_d;
	logic                     dirty_d;
	logic                     save_d;
	logic [TIMER_W-1:0]       relay_age_inc;
	logic [TIMER_W-1:0]       relay_age_d;
	logic                     want;
	logic                     relay_d;
	result_item_t             result_d;

	// Clamp to the limits; if they cross, v < lo gives lo, else hi.
	function automatic logic signed [TEMP_W-1:0] clamp_sp(
		input logic signed [13:0] v,
		input logic signed [13:0] lo,
		input logic signed [13:0] hi
	);
		logic signed [13:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r[TEMP_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Handshakes. The input register moves on whenever its item is
	// processed, so only a full input register behind a stalled result
	// holds off the source.
	// ------------------------------------------------------------------
	assign advance   = vld_s1 && (!res_vld_s2 || !res_stall);
	assign src_stall = vld_s1 && res_vld_s2 && res_stall;
	assign res_valid = res_vld_s2;
	assign res_item  = res_item_s2;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall) begin
			item_s1 <= src_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (advance) begin
			res_vld_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_item_s2 <= result_d;
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers. All eight codes are valid register indexes.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_band_q  <= HALF_BAND_RST;
			sp_low_q     <= SP_LOW_RST;
			sp_high_q    <= SP_HIGH_RST;
			sp_step_q    <= SP_STEP_RST;
			min_toggle_q <= MIN_TOGGLE_RST;
			debounce_q   <= DEBOUNCE_RST;
			repeat_q     <= REPEAT_RST;
			save_quiet_q <= SAVE_QUIET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_BAND:     half_band_q  <= cfg_data[7:0];
				REG_SETPOINT_LOW:  sp_low_q     <= cfg_data[11:0];
				REG_SETPOINT_HIGH: sp_high_q    <= cfg_data[11:0];
				REG_SETPOINT_STEP: sp_step_q    <= cfg_data[7:0];
				REG_MIN_TOGGLE:    min_toggle_q <= cfg_data;
				REG_DEBOUNCE:      debounce_q   <= cfg_data[7:0];
				REG_REPEAT:        repeat_q     <= cfg_data[11:0];
				REG_SAVE_QUIET:    save_quiet_q <= cfg_data;
				default:           half_band_q  <= half_band_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Button lanes. Whether a button fires depends only on its own pin
	// history, so both lanes are evaluated side by side; the setpoint then
	// takes the up step before the down step.
	// ------------------------------------------------------------------
	assign level[0] = item_s1.up_level;
	assign level[1] = item_s1.down_level;

	always_comb begin
		logic [DEB_W-1:0] db_inc;
		logic [REP_W-1:0] rp_inc;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			db_inc = (db_age_q[b] == DEB_MAX) ? DEB_MAX : db_age_q[b] + 1'b1;
			rp_inc = (rp_age_q[b] == REP_MAX) ? REP_MAX : rp_age_q[b] + 1'b1;
			// A pin edge restarts the debounce window.
			db_age_d[b] = (level[b] != last_q[b]) ? '0 : db_inc;
			rp_age_d[b] = rp_inc;
			stable_d[b] = stable_q[b];
			fire[b]     = 1'b0;
			if (db_age_d[b] >= debounce_q) begin
				if (stable_q[b] != level[b]) begin
					stable_d[b] = level[b];
					if (!level[b]) begin
						fire[b]     = 1'b1;
						rp_age_d[b] = '0;
					end
				end else if (!level[b] && rp_inc >= repeat_q) begin
					fire[b]     = 1'b1;
					rp_age_d[b] = '0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Setpoint, save request and relay decision for one tick.
	// ------------------------------------------------------------------
	always_comb begin
		sp_lo_x = 14'(signed'(sp_low_q));
		sp_hi_x = 14'(signed'(sp_high_q));
		step_x  = signed'({6'd0, sp_step_q});
		half_x  = signed'({6'd0, half_band_q});
		temp_x  = 14'(item_s1.temperature);

		remote_ok = item_s1.remote_write &&
			(14'(item_s1.remote_setpoint) >= sp_lo_x) &&
			(14'(item_s1.remote_setpoint) <= sp_hi_x);
		sp_remote = remote_ok ? item_s1.remote_setpoint : setpoint_q;
		sp_up = fire[0] ? clamp_sp(14'(sp_remote) + step_x, sp_lo_x, sp_hi_x) : sp_remote;
		sp_d  = fire[1] ? clamp_sp(14'(sp_up) - step_x, sp_lo_x, sp_hi_x) : sp_up;

		// Any accepted change restarts the quiet timer.
		mark    = remote_ok || fire[0] || fire[1];
		quiet_d = mark ? '0 : ((quiet_age_q == TIMER_MAX) ? TIMER_MAX : quiet_age_q + 1'b1);
		dirty_d = dirty_q || mark;
		save_d  = 1'b0;
		if (dirty_d && (32'(quiet_d) >= 32'(save_quiet_q))) begin
			save_d  = 1'b1;
			dirty_d = 1'b0;
		end

		// Cooling relay with hysteresis; an invalid sample asks for it off.
		if (!item_s1.temp_valid) begin
			want = 1'b0;
		end else if (temp_x >= 14'(sp_d) + half_x) begin
			want = 1'b1;
		end else if (temp_x <= 14'(sp_d) - half_x) begin
			want = 1'b0;
		end else begin
			want = relay_q;
		end
		relay_age_inc = (relay_age_q == TIMER_MAX) ? TIMER_MAX : relay_age_q + 1'b1;
		relay_d       = relay_q;
		relay_age_d   = relay_age_inc;
		if (want != relay_q && (32'(relay_age_inc) >= 32'(min_toggle_q))) begin
			relay_d     = want;
			relay_age_d = '0;
		end

		result_d.relay_on     = relay_d;
		result_d.setpoint_now = sp_d;
		result_d.save_pulse   = save_d;
		result_d.local_change = fire[0] || fire[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= 1'b0;
			relay_age_q <= '0;
			setpoint_q  <= SETPOINT_RST;
			dirty_q     <= 1'b0;
			quiet_age_q <= '0;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				stable_q[b] <= 1'b1;
				last_q[b]   <= 1'b1;
				db_age_q[b] <= '0;
				rp_age_q[b] <= '0;
			end
		end else if (advance) begin
			relay_q     <= relay_d;
			relay_age_q <= relay_age_d;
			setpoint_q  <= sp_d;
			dirty_q     <= dirty_d;
			quiet_age_q <= quiet_d;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				stable_q[b] <= stable_d[b];
				last_q[b]   <= level[b];
				db_age_q[b] <= db_age_d[b];
				rp_age_q[b] <= rp_age_d[b];
			end
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// A relay change always restarts the toggle timer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(relay_q != $past(relay_q)) |-> (relay_age_q == '0))
		else $error("relay changed without restarting its timer");

	// A save request clears the pending-save flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && save_d) |=> !dirty_q)
		else $error("pending save flag survived a save request");

	// The source is held off only behind a full input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (vld_s1 && res_vld_s2))
		else $error("source stalled while the pipeline had room");

endmodule

[tb/hysteresis_thermostat_with_buttons_top_tb.sv]
// ----------------------------------------------------------------------------
// hysteresis_thermostat_with_buttons_top_tb
// Self-checking bench for the hysteresis thermostat with setpoint buttons.
// Ticks are offered on the src channel from a queue. Every accepted tick runs
// through a cycle-free model of the relay, button and save logic, and each
// result item that leaves the block is compared with the oldest prediction.
// The run walks through several register settings, the extremes among them,
// with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_with_buttons_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	// Wait after the last answer before the registers are touched again.
	localparam int SETTLE_CYCLES = 6;
	localparam int unsigned TIMER_MAX = (1 << TIMER_W) - 1;
	localparam int unsigned DEBOUNCE_MAX = 255;
	localparam int unsigned REPEAT_MAX = 4095;
	localparam int TEMP_MIN = -880;
	localparam int TEMP_MAX = 2000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         src_valid = 1'b0;
	logic         src_stall;
	tick_item_t   src_item = '0;
	logic         res_valid;
	logic         res_stall = 1'b0;
	result_item_t res_item;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	cfg_reg_t     cfg_index = REG_HALF_BAND;
	logic [15:0]  cfg_data = '0;

	hysteresis_thermostat_with_buttons_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Ticks waiting to be offered, and results that the thermostat model
	// says must come back, oldest first.
	tick_item_t   tick_queue [$];
	result_item_t results_expected [$];
	result_item_t oldest_expected;

	// Idling controls shared by the stimulus, the driver and the receiver.
	int  src_idle_pct = 25;
	int  res_idle_pct = 25;
	bit  calm = 1'b0;
	int  hold_len = 0;
	int  holds_asked = 0;

	int  ticks_sent = 0;
	int  results_checked = 0;
	int  mismatches = 0;
	int  relay_flips = 0;
	int  save_count = 0;
	int  step_count = 0;
	int  cycle_count = 0;

	// Register copies as the thermostat sees them. They start at the reset
	// values and follow every write on the cfg channel.
	int          cfg_half = 12;
	int          cfg_sp_low = -80;
	int          cfg_sp_high = 480;
	int          cfg_step = 8;
	int unsigned cfg_min_toggle = 10000;
	int unsigned cfg_debounce = 50;
	int unsigned cfg_repeat = 250;
	int unsigned cfg_save_quiet = 3000;

	// Thermostat state after reset: relay off, eight degrees, buttons up.
	bit          relay_q = 1'b0;
	int unsigned relay_age = 0;
	int          setpoint = 128;
	bit          dirty = 1'b0;
	int unsigned quiet_age = 0;
	bit          stable_lvl [2] = '{1'b1, 1'b1};
	bit          last_lvl [2] = '{1'b1, 1'b1};
	int unsigned deb_age [2] = '{0, 0};
	int unsigned rep_age [2] = '{0, 0};

	// One button for one tick: debounce the raw pin, then step the setpoint
	// on a fresh press or on each repeat interval while it stays pressed.
	// Returns 1 when the button fired, even if the clamp kept the value.
	function automatic bit button_fires(int b, bit lvl, int delta);
		bit fire;
		int v;
		fire = 1'b0;
		deb_age[b] = (deb_age[b] >= DEBOUNCE_MAX) ? DEBOUNCE_MAX : deb_age[b] + 1;
		rep_age[b] = (rep_age[b] >= REPEAT_MAX) ? REPEAT_MAX : rep_age[b] + 1;
		if (lvl != last_lvl[b]) begin
			deb_age[b] = 0;
			last_lvl[b] = lvl;
		end
		if (deb_age[b] >= cfg_debounce) begin
			if (stable_lvl[b] != lvl) begin
				stable_lvl[b] = lvl;
				fire = !lvl;
			end else begin
				fire = !lvl && rep_age[b] >= cfg_repeat;
			end
			if (fire) begin
				// With crossed limits, v below the low limit gets it, else the high.
				v = setpoint + delta;
				if (v < cfg_sp_low)
					v = cfg_sp_low;
				else if (v > cfg_sp_high)
					v = cfg_sp_high;
				setpoint = v;
				dirty = 1'b1;
				quiet_age = 0;
				rep_age[b] = 0;
			end
		end
		return fire;
	endfunction

	// Advances the thermostat by one tick and returns the result item that
	// the block must produce for it.
	function automatic result_item_t thermo_tick(tick_item_t t);
		result_item_t r;
		int temp;
		int remote_sp;
		bit want;
		bit local_chg;
		bit save;
		temp = $signed(t.temperature);
		remote_sp = $signed(t.remote_setpoint);
		save = 1'b0;
		relay_age = (relay_age >= TIMER_MAX) ? TIMER_MAX : relay_age + 1;
		quiet_age = (quiet_age >= TIMER_MAX) ? TIMER_MAX : quiet_age + 1;

		if (t.remote_write && remote_sp >= cfg_sp_low && remote_sp <= cfg_sp_high) begin
			setpoint = remote_sp;
			dirty = 1'b1;
			quiet_age = 0;
		end

		// Up is handled before down within the same tick.
		local_chg = button_fires(0, t.up_level, cfg_step);
		local_chg = button_fires(1, t.down_level, -cfg_step) | local_chg;

		if (dirty && quiet_age >= cfg_save_quiet) begin
			save = 1'b1;
			dirty = 1'b0;
		end

		// An invalid probe sample always asks for the relay to drop. A change
		// that comes too early is dropped and asked for again next tick.
		want = relay_q;
		if (!t.temp_valid)
			want = 1'b0;
		else if (temp >= setpoint + cfg_half)
			want = 1'b1;
		else if (temp <= setpoint - cfg_half)
			want = 1'b0;
		if (want != relay_q && relay_age >= cfg_min_toggle) begin
			relay_q = want;
			relay_age = 0;
			relay_flips++;
		end

		save_count += save;
		step_count += local_chg;
		r.relay_on = relay_q;
		r.setpoint_now = 12'(setpoint);
		r.save_pulse = save;
		r.local_change = local_chg;
		return r;
	endfunction

	// Sender: offers the head of the queue and keeps it steady while the block
	// stalls. Gaps are only inserted after an item has been taken.
	int src_gap = 0;
	always @(posedge clk) begin
		if (src_valid && !src_stall) begin
			void'(tick_queue.pop_front());
			ticks_sent++;
			if (!calm && $urandom_range(99) < src_idle_pct)
				src_gap = $urandom_range(10, 1);
		end
		if (!(src_valid && src_stall)) begin
			if (src_gap != 0) begin
				src_gap--;
				src_valid <= 1'b0;
			end else if (tick_queue.size() != 0) begin
				src_valid <= 1'b1;
				src_item <= tick_queue[0];
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request that is
	// counted down here so that the sender keeps pushing meanwhile.
	int holds_started = 0;
	int hold_left = 0;
	int res_burst = 0;
	always @(posedge clk) begin
		if (holds_started != holds_asked) begin
			holds_started++;
			hold_left = hold_len;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (res_burst != 0) begin
			res_burst--;
			res_stall <= 1'b1;
		end else if (!calm && $urandom_range(99) < res_idle_pct) begin
			res_burst = $urandom_range(9);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Observer: tracks register writes, predicts accepted ticks and checks
	// every result item against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HALF_BAND:     cfg_half = cfg_data[7:0];
					REG_SETPOINT_LOW:  cfg_sp_low = $signed(cfg_data[11:0]);
					REG_SETPOINT_HIGH: cfg_sp_high = $signed(cfg_data[11:0]);
					REG_SETPOINT_STEP: cfg_step = cfg_data[7:0];
					REG_MIN_TOGGLE:    cfg_min_toggle = cfg_data;
					REG_DEBOUNCE:      cfg_debounce = cfg_data[7:0];
					REG_REPEAT:        cfg_repeat = cfg_data[11:0];
					REG_SAVE_QUIET:    cfg_save_quiet = cfg_data;
					default: ;
				endcase
			end
			if (src_valid && !src_stall)
				results_expected.push_back(thermo_tick(src_item));
			if (res_valid && !res_stall) begin
				results_checked++;
				if (results_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("Result %0d arrived with no tick waiting for it", results_checked);
				end else begin
					oldest_expected = results_expected.pop_front();
					if (res_item.relay_on !== oldest_expected.relay_on ||
					    res_item.setpoint_now !== oldest_expected.setpoint_now ||
					    res_item.save_pulse !== oldest_expected.save_pulse ||
					    res_item.local_change !== oldest_expected.local_change) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("Result %0d: expected relay %0b setpoint %0d save %0b step %0b, got relay %0b setpoint %0d save %0b step %0b",
								results_checked, oldest_expected.relay_on,
								oldest_expected.setpoint_now, oldest_expected.save_pulse,
								oldest_expected.local_change, res_item.relay_on,
								res_item.setpoint_now, res_item.save_pulse,
								res_item.local_change);
					end
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(int half, int lo, int hi, int step_size, int min_tog,
	                            int deb, int rep, int quiet);
		write_reg(REG_HALF_BAND, 16'(half));
		write_reg(REG_SETPOINT_LOW, 16'(lo));
		write_reg(REG_SETPOINT_HIGH, 16'(hi));
		write_reg(REG_SETPOINT_STEP, 16'(step_size));
		write_reg(REG_MIN_TOGGLE, 16'(min_tog));
		write_reg(REG_DEBOUNCE, 16'(deb));
		write_reg(REG_REPEAT, 16'(rep));
		write_reg(REG_SAVE_QUIET, 16'(quiet));
	endtask

	task automatic push_tick(bit valid, int temp, bit up, bit down, bit rw, int rsp);
		tick_item_t t;
		t.temp_valid = valid;
		t.temperature = 12'(temp);
		t.up_level = up;
		t.down_level = down;
		t.remote_write = rw;
		t.remote_setpoint = 12'(rsp);
		tick_queue.push_back(t);
	endtask

	// Waits until every tick has been taken and answered, then lets the
	// pipeline settle so that registers may be written again.
	task automatic drain();
		do @(negedge clk); while (tick_queue.size() != 0 || results_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random phase. Buttons are held for random spans: short spans act
	// as contact bounce, longer ones get through the debounce and repeat.
	// The probe wanders around the setpoint window with rare jumps anywhere.
	task automatic run_phase(int half, int lo, int hi, int step_size, int min_tog, int deb,
	                         int rep, int quiet, int n, int src_pct, int res_pct, int hold);
		int i;
		int b;
		int r;
		int wlo;
		int whi;
		int wstep;
		int temp;
		int rsp;
		bit lvl [2];
		int unsigned left [2];
		apply_config(half, lo, hi, step_size, min_tog, deb, rep, quiet);
		@(negedge clk);
		src_idle_pct = src_pct;
		res_idle_pct = res_pct;
		wlo = ((lo < hi) ? lo : hi) - half - 40;
		whi = ((lo > hi) ? lo : hi) + half + 40;
		if (wlo < TEMP_MIN)
			wlo = TEMP_MIN;
		if (whi > TEMP_MAX)
			whi = TEMP_MAX;
		wstep = half / 2 + 6;
		temp = (wlo + whi) / 2;
		lvl = '{1'b1, 1'b1};
		left = '{0, 0};
		for (i = 0; i < n; i++) begin
			for (b = 0; b < 2; b++) begin
				if (left[b] == 0) begin
					lvl[b] = ~lvl[b];
					r = $urandom_range(99);
					if (r < 35)
						left[b] = $urandom_range(3, 1);
					else if (r < 85)
						left[b] = $urandom_range(60, 4);
					else
						left[b] = $urandom_range(320, 61);
				end
				left[b]--;
			end

			if ($urandom_range(99) < 3) begin
				temp = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
			end else begin
				temp += int'($urandom_range(2 * wstep)) - wstep;
				if (temp < wlo || temp > whi)
					temp = wlo + int'($urandom_range(whi - wlo));
			end

			// Remote values favor the window and its edges, just inside
			// and just outside.
			r = $urandom_range(99);
			if (r < 40 && lo <= hi) begin
				rsp = lo + int'($urandom_range(hi - lo));
			end else if (r < 65) begin
				case ($urandom_range(3))
					0: rsp = lo;
					1: rsp = hi;
					2: rsp = lo - 1;
					default: rsp = hi + 1;
				endcase
				if (rsp < TEMP_MIN)
					rsp = TEMP_MIN;
				if (rsp > TEMP_MAX)
					rsp = TEMP_MAX;
			end else begin
				rsp = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
			end

			push_tick($urandom_range(99) >= 4, temp, lvl[0], lvl[1],
				$urandom_range(99) < 4, rsp);
		end
		if (hold != 0) begin
			hold_len = hold;
			holds_asked++;
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: the relay cannot move yet, so this checks the
		// remote limits at and just past both edges and bounce that never
		// outlasts the debounce time.
		@(negedge clk);
		push_tick(1'b1, TEMP_MAX, 1'b1, 1'b1, 1'b0, 0);
		push_tick(1'b0, TEMP_MIN, 1'b1, 1'b1, 1'b0, 0);
		push_tick(1'b1, 100, 1'b1, 1'b1, 1'b1, 480);
		push_tick(1'b1, 100, 1'b1, 1'b1, 1'b1, 481);
		push_tick(1'b1, 100, 1'b1, 1'b1, 1'b1, -80);
		push_tick(1'b1, 100, 1'b1, 1'b1, 1'b1, -81);
		push_tick(1'b1, TEMP_MIN, 1'b1, 1'b1, 1'b1, TEMP_MAX);
		push_tick(1'b1, 0, 1'b0, 1'b0, 1'b0, 0);
		push_tick(1'b1, 0, 1'b1, 1'b0, 1'b0, 0);
		push_tick(1'b1, 0, 1'b1, 1'b1, 1'b1, TEMP_MIN);
		drain();

		// Zero band, no toggle delay, no debounce, repeat every tick and an
		// immediate save. Setpoint is -80 here. Covers the tie at the
		// setpoint, the invalid sample, clamping at both limits with the
		// step flag still set, both buttons at once, and a remote value
		// followed by a button step in the same tick.
		apply_config(0, TEMP_MIN, TEMP_MAX, 255, 0, 0, 0, 0);
		@(negedge clk);
		push_tick(1'b1, -80, 1'b1, 1'b1, 1'b0, 0);
		push_tick(1'b1, -81, 1'b1, 1'b1, 1'b0, 0);
		push_tick(1'b1, TEMP_MAX, 1'b1, 1'b1, 1'b0, 0);
		push_tick(1'b0, TEMP_MAX, 1'b1, 1'b1, 1'b0, 0);
		push_tick(1'b1, 500, 1'b0, 1'b1, 1'b0, 0);
		push_tick(1'b1, 500, 1'b0, 1'b1, 1'b1, 1900);
		push_tick(1'b1, TEMP_MAX, 1'b0, 1'b1, 1'b0, 0);
		push_tick(1'b1, 1000, 1'b1, 1'b0, 1'b0, 0);
		push_tick(1'b1, 1000, 1'b0, 1'b0, 1'b0, 0);
		push_tick(1'b1, TEMP_MIN, 1'b1, 1'b0, 1'b1, TEMP_MIN);
		push_tick(1'b1, TEMP_MIN, 1'b1, 1'b1, 1'b0, 0);
		push_tick(1'b0, 0, 1'b1, 1'b1, 1'b1, TEMP_MAX);
		drain();

		// Reset-like window with short timers.
		run_phase(12, -80, 480, 8, 3, 2, 5, 10, 300, 20, 20, 0);
		// Every register at its top, limits crossed so that remote values
		// are refused and button steps land on one of the two limits.
		run_phase(255, TEMP_MAX, TEMP_MIN, 255, 65535, 255, 4095, 65535, 150, 30, 30, 0);
		// Narrowest band and step with zero delays, and no idling at all.
		run_phase(1, TEMP_MIN, TEMP_MAX, 1, 0, 0, 1, 0, 300, 0, 0, 0);
		// The receiver holds off long enough for the block to stall its input.
		run_phase(30, 0, 400, 16, 20, 4, 12, 40, 400, 10, 15, 300);
		// Single allowed setpoint and a step of zero.
		run_phase(5, -200, -200, 0, 1, 1, 4095, 5, 200, 40, 40, 0);

		// The closing stretch runs at full rate on both sides.
		@(negedge clk);
		calm = 1'b1;
		run_phase(8, -100, 600, 8, 5, 3, 8, 25, 520, 0, 0, 0);

		repeat (10) @(posedge clk);
		mismatches += results_expected.size();
		$display("Drove %0d ticks over eight register settings and checked %0d results.",
			ticks_sent, results_checked);
		$display("Predicted %0d relay changes, %0d save requests and %0d button steps.",
			relay_flips, save_count, step_count);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d results were wrong or missing", mismatches);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/hts_pkg.sv
hw/rtl/hysteresis_thermostat_with_buttons_top.sv
tb/hysteresis_thermostat_with_buttons_top_tb.sv
